// ----- rtl/core/sbmt_pkg.sv -----
// Shared types and codes for the sparse block matrix transpose.
// Used by the front end, request queue, back end, top level and checker.
package sbmt_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_PTR   = 2'd1;
  localparam logic [1:0] KIND_ENTRY = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_OVERFLOW = 3'd1;
  localparam logic [2:0] ERR_ROW      = 3'd2;
  localparam logic [2:0] ERR_COL      = 3'd3;
  localparam logic [2:0] ERR_EARLY    = 3'd4;

  // Configuration register indexes.
  localparam logic REG_SOURCE_ROWS = 1'b0;
  localparam logic REG_SOURCE_COLS = 1'b1;

  // A classified request as it travels from the front end to the back end.
  typedef struct packed {
    logic       is_fetch;
    logic [9:0] row;
    logic [9:0] col;
    logic       fin;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  kind;
    logic [12:0] value;
    logic [11:0] spos;
    logic        done;
    logic [2:0]  err;
  } res_t;

endpackage

// ----- rtl/core/sbmt_front.sv -----
// Front end: accepts input requests and classifies them into queue items.
// Depends on sbmt_pkg for the request type.
module sbmt_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          op,
  input  logic [9:0]    row_index,
  input  logic [9:0]    col_index,
  input  logic          final_entry,
  output logic          push,
  output sbmt_pkg::req_t push_item,
  input  logic          push_ready
);
  import sbmt_pkg::*;

  logic f_valid;
  req_t f_item;

  // The holding register frees up whenever the queue takes its request.
  assign in_ready  = !f_valid || push_ready;
  assign push      = f_valid;
  assign push_item = f_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_ready) begin
      f_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      f_item.is_fetch <= op;
      f_item.row      <= row_index;
      f_item.col      <= col_index;
      f_item.fin      <= final_entry & ~op;
    end
  end

endmodule

// ----- rtl/core/sbmt_queue.sv -----
// Two-entry request queue between the front end and the back end.
// Depends on sbmt_pkg for the request type.
module sbmt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sbmt_pkg::req_t push_item,
  output logic          push_ready,
  output logic          pop_valid,
  output sbmt_pkg::req_t pop_item,
  input  logic          pop
);
  import sbmt_pkg::*;

  req_t       slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_item   = slots[rp];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      fill <= fill + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) slots[wp] <= push_item;
  end

endmodule

// ----- rtl/core/sbmt_back.sv -----
// Back end: entry stores, counting sort sequencer, drain and output register.
// Depends on sbmt_pkg for request, result and code definitions.
module sbmt_back #(
  parameter int MAX_ENTRIES = 4096,
  parameter int MAX_DIM     = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  sbmt_pkg::req_t q_item,
  output logic           q_pop,
  input  logic [10:0]    cfg_rows,
  input  logic [10:0]    cfg_cols,
  output logic           out_valid,
  input  logic           out_ready,
  output sbmt_pkg::res_t out_res
);
  import sbmt_pkg::*;

  localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int DW  = $clog2(MAX_DIM + 1);
  localparam int PAW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DPW = $clog2(MAX_DIM + MAX_ENTRIES + 1);
  localparam int TW  = 10 + AW;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_CLR, S_C0, S_C1, S_C2, S_P0, S_P1, S_S0, S_S1, S_S2
  } state_t;

  typedef enum logic [1:0] {F_ZERO, F_PTR, F_ENTRY, F_NONE} fsel_t;

  // Memories.
  logic [19:0]   ld_mem  [MAX_ENTRIES];
  logic [TW-1:0] tr_mem  [MAX_ENTRIES];
  logic [CW-1:0] ptr_mem [MAX_DIM];
  logic [19:0]   ld_q;
  logic [TW-1:0] tr_q;
  logic [CW-1:0] ptr_q;

  // Control and data registers.
  state_t         state;
  fsel_t          fsel;
  logic           fdone;
  logic           draining;
  logic [CW-1:0]  entry_count;
  logic [9:0]     last_row;
  logic [DPW-1:0] dp;
  logic [DW-1:0]  rows_n;
  logic [CW-1:0]  total;
  logic [CW-1:0]  idx;
  logic [DW-1:0]  j;
  logic [CW-1:0]  acc;
  logic [DW-1:0]  n_s;
  logic [DW-1:0]  m_s;
  logic [PAW-1:0] cur_c;
  logic [9:0]     cur_r;

  // Combinational signals.
  logic           out_free;
  logic [DW-1:0]  n_live;
  logic [DW-1:0]  m_live;
  logic [2:0]     load_err;
  logic [9:0]     lr;
  logic [9:0]     lc;
  logic           lvalid;
  logic [DPW-1:0] last;
  logic           ld_we, ld_re, tr_we, tr_re, ptr_we, ptr_re;
  logic [AW-1:0]  ld_waddr, ld_raddr, tr_waddr, tr_raddr;
  logic [PAW-1:0] ptr_waddr, ptr_raddr;
  logic [CW-1:0]  ptr_wdata;
  logic [TW-1:0]  tr_wdata;
  logic           fetch_pop;
  logic           out_valid_next;
  res_t           out_res_next;

  function automatic logic [DW-1:0] clamp_dim(input logic [10:0] v);
    if (32'(v) > MAX_DIM) clamp_dim = DW'(MAX_DIM);
    else clamp_dim = DW'(v);
  endfunction

  assign out_free  = !out_valid || out_ready;
  assign q_pop     = (state == S_IDLE) && q_valid && out_free;
  assign fetch_pop = q_pop && q_item.is_fetch && draining;
  assign n_live    = clamp_dim(cfg_cols);
  assign m_live    = clamp_dim(cfg_rows);
  assign lr        = ld_q[19:10];
  assign lc        = ld_q[9:0];
  assign lvalid    = (32'(lc) < 32'(n_s)) && (32'(lr) < 32'(m_s));
  assign last      = DPW'(rows_n) + DPW'(total);

  // Load checks in priority order: overflow, row, column.
  always_comb begin
    if (32'(entry_count) >= MAX_ENTRIES) load_err = ERR_OVERFLOW;
    else if (q_item.row < last_row || 32'(q_item.row) >= 32'(m_live)) load_err = ERR_ROW;
    else if (32'(q_item.col) >= 32'(n_live)) load_err = ERR_COL;
    else load_err = ERR_OK;
  end

  // Memory port control for every state.
  always_comb begin
    ld_we     = q_pop && !q_item.is_fetch && !draining && (load_err == ERR_OK);
    ld_waddr  = entry_count[AW-1:0];
    ld_re     = (state == S_C0) || (state == S_S0);
    ld_raddr  = idx[AW-1:0];
    tr_we     = (state == S_S2);
    tr_waddr  = ptr_q[AW-1:0];
    tr_wdata  = {cur_r, idx[AW-1:0]};
    tr_re     = fetch_pop && (dp > DPW'(rows_n));
    tr_raddr  = AW'(dp - DPW'(rows_n) - DPW'(1));
    ptr_we    = 1'b0;
    ptr_waddr = cur_c;
    ptr_wdata = ptr_q + CW'(1);
    ptr_re    = 1'b0;
    ptr_raddr = lc[PAW-1:0];
    case (state)
      S_IDLE: begin
        ptr_re    = fetch_pop && (dp != '0) && (dp <= DPW'(rows_n));
        ptr_raddr = PAW'(dp - DPW'(1));
      end
      S_CLR: begin
        ptr_we    = (j != n_s);
        ptr_waddr = PAW'(j);
        ptr_wdata = '0;
      end
      S_C1, S_S1: begin
        ptr_re = lvalid;
      end
      S_C2, S_S2: begin
        ptr_we = 1'b1;
      end
      S_P0: begin
        ptr_re    = (j != n_s);
        ptr_raddr = PAW'(j);
      end
      S_P1: begin
        ptr_we    = 1'b1;
        ptr_waddr = PAW'(j);
        ptr_wdata = acc;
      end
      default: begin
      end
    endcase
  end

  // Next output register contents: load and early fetch answers come straight
  // from the idle state, drained items out of the fetch wait state.
  always_comb begin
    out_valid_next = out_valid && !out_ready;
    out_res_next   = out_res;
    case (state)
      S_IDLE: begin
        if (q_pop && !(q_item.is_fetch && draining)) begin
          out_valid_next = 1'b1;
          out_res_next   = '0;
          if (!q_item.is_fetch) begin
            if (!draining) out_res_next.err = load_err;
          end else begin
            out_res_next.err = ERR_EARLY;
          end
        end
      end
      S_FETCH: begin
        if (out_free) begin
          out_valid_next    = 1'b1;
          out_res_next      = '0;
          out_res_next.done = fdone;
          case (fsel)
            F_PTR: begin
              out_res_next.kind  = KIND_PTR;
              out_res_next.value = 13'(ptr_q);
            end
            F_ENTRY: begin
              out_res_next.kind  = KIND_ENTRY;
              out_res_next.value = 13'(tr_q[TW-1:AW]);
              out_res_next.spos  = 12'(tr_q[AW-1:0]);
            end
            default: begin
              out_res_next.kind = KIND_PTR;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // Loaded entries as {row, column}.
  always_ff @(posedge clk) begin
    if (ld_we) ld_mem[ld_waddr] <= {q_item.row, q_item.col};
    if (ld_re) ld_q <= ld_mem[ld_raddr];
  end

  // Transposed entries as {old row, load position}.
  always_ff @(posedge clk) begin
    if (tr_we) tr_mem[tr_waddr] <= tr_wdata;
    if (tr_re) tr_q <= tr_mem[tr_raddr];
  end

  // Column counts, then column starts, then column ends.
  always_ff @(posedge clk) begin
    if (ptr_we) ptr_mem[ptr_waddr] <= ptr_wdata;
    if (ptr_re) ptr_q <= ptr_mem[ptr_raddr];
  end

  // Sequencer, drain state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      draining    <= 1'b0;
      entry_count <= '0;
      last_row    <= '0;
      dp          <= '0;
      rows_n      <= '0;
      total       <= '0;
      out_valid   <= 1'b0;
      fsel        <= F_NONE;
      fdone       <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      out_res   <= out_res_next;
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            if (!q_item.is_fetch) begin
              if (!draining) begin
                if (load_err == ERR_OK) begin
                  entry_count <= entry_count + CW'(1);
                  last_row    <= q_item.row;
                end
                if (q_item.fin) begin
                  n_s   <= n_live;
                  m_s   <= m_live;
                  j     <= '0;
                  state <= S_CLR;
                end
              end
            end else if (draining) begin
              // The result comes out of the fetch wait state.
              if (dp == '0) fsel <= F_ZERO;
              else if (dp <= DPW'(rows_n)) fsel <= F_PTR;
              else fsel <= F_ENTRY;
              fdone <= (dp >= last);
              if (dp >= last) begin
                draining    <= 1'b0;
                entry_count <= '0;
                last_row    <= '0;
                dp          <= '0;
              end else begin
                dp <= dp + DPW'(1);
              end
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_CLR: begin
          if (j == n_s) begin
            idx   <= '0;
            total <= '0;
            state <= S_C0;
          end else begin
            j <= j + DW'(1);
          end
        end
        S_C0: begin
          if (idx == entry_count) begin
            j     <= '0;
            acc   <= '0;
            state <= S_P0;
          end else begin
            state <= S_C1;
          end
        end
        S_C1: begin
          cur_c <= lc[PAW-1:0];
          if (lvalid) begin
            state <= S_C2;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_C0;
          end
        end
        S_C2: begin
          total <= total + CW'(1);
          idx   <= idx + CW'(1);
          state <= S_C0;
        end
        S_P0: begin
          if (j == n_s) begin
            idx   <= '0;
            state <= S_S0;
          end else begin
            state <= S_P1;
          end
        end
        S_P1: begin
          acc   <= acc + ptr_q;
          j     <= j + DW'(1);
          state <= S_P0;
        end
        S_S0: begin
          if (idx == entry_count) begin
            draining <= 1'b1;
            dp       <= '0;
            rows_n   <= n_s;
            state    <= S_IDLE;
          end else begin
            state <= S_S1;
          end
        end
        S_S1: begin
          cur_c <= lc[PAW-1:0];
          cur_r <= lr;
          if (lvalid) begin
            state <= S_S2;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_S0;
          end
        end
        S_S2: begin
          idx   <= idx + CW'(1);
          state <= S_S0;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/sparse_block_matrix_transpose.sv -----
// A load or fetch passes the front end's holding register and the request queue,
// and the back end answers from its output register. It takes a new load while idle
// and that register is free, and holds further requests while a fetch awaits output.
// After the final load the counting sort makes single-port passes over the stores.
// Reset is synchronous: control state clears, entry stores are not cleared,
// and the column store is cleared at the start of each transposition.
module sparse_block_matrix_transpose #(
  parameter int MAX_ENTRIES = 4096,
  parameter int MAX_DIM     = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [9:0]  row_index,
  input  logic [9:0]  col_index,
  input  logic        final_entry,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [12:0] value,
  output logic [11:0] source_position,
  output logic        drain_done,
  output logic [2:0]  error_code
);
  import sbmt_pkg::*;

  logic [10:0] source_rows;
  logic [10:0] source_cols;
  logic        f_push;
  req_t        f_item;
  logic        q_ready;
  logic        q_valid;
  req_t        q_item;
  logic        q_pop;
  res_t        res;

  // Configuration registers.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      source_rows <= 11'd1024;
      source_cols <= 11'd1024;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_SOURCE_ROWS) source_rows <= pwdata[10:0];
      else source_cols <= pwdata[10:0];
    end
  end
  assign prdata = (paddr[2] == REG_SOURCE_ROWS) ? {21'd0, source_rows}
                                                : {21'd0, source_cols};

  sbmt_front u_front (
    .clk, .rst, .in_valid, .in_ready, .op, .row_index, .col_index, .final_entry,
    .push(f_push), .push_item(f_item), .push_ready(q_ready)
  );

  sbmt_queue u_queue (
    .clk, .rst, .push(f_push), .push_item(f_item), .push_ready(q_ready),
    .pop_valid(q_valid), .pop_item(q_item), .pop(q_pop)
  );

  sbmt_back #(.MAX_ENTRIES(MAX_ENTRIES), .MAX_DIM(MAX_DIM)) u_back (
    .clk, .rst, .q_valid, .q_item, .q_pop, .cfg_rows(source_rows),
    .cfg_cols(source_cols), .out_valid, .out_ready, .out_res(res)
  );

  assign kind            = res.kind;
  assign value           = res.value;
  assign source_position = res.spos;
  assign drain_done      = res.done;
  assign error_code      = res.err;

endmodule

// ----- rtl/core/sbmt_checker.sv -----
// Port-level checks for the sparse block matrix transpose, bound to the top.
// Depends on sbmt_pkg for result kinds and error codes.
module sbmt_checker (
  input logic        clk,
  input logic        rst,
  input logic        pready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [12:0] value,
  input logic        drain_done,
  input logic [2:0]  error_code
);
  import sbmt_pkg::*;

  // A result waiting for the consumer is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result withdrawn");

  // An error answer never carries a pointer or an entry.
  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != ERR_OK |-> kind == KIND_NONE)
    else $error("error with payload");

  // The end of a drain is always a drained item without error.
  a_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && drain_done |-> kind != KIND_NONE && error_code == ERR_OK)
    else $error("bad drain end");

  // A transposed entry's new column is an old row index.
  a_entry_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ENTRY |-> value < 13'd1024)
    else $error("entry column out of range");

  // The configuration port never stalls.
  a_pready: assert property (@(posedge clk) pready) else $error("pready low");

endmodule

bind sparse_block_matrix_transpose sbmt_checker u_sbmt_checker (
  .clk, .rst, .pready, .out_valid, .out_ready, .kind, .value, .drain_done, .error_code
);

// ----- verif/sparse_block_matrix_transpose_test.sv -----
// Self-checking testbench for the sparse block matrix transpose.
// Depends on sbmt_pkg and the sparse_block_matrix_transpose top level only.
module sparse_block_matrix_transpose_test;
  import sbmt_pkg::*;

  localparam int MAX_ENTRIES = 4096;
  localparam int MAX_DIM     = 1024;
  localparam int STALL_LIMIT = 100000;
  localparam int RANDOM_REQS = 1100;
  localparam int LONG_HOLD   = 300;

  // Keeps its own copy of the block state and predicts every result.
  class transpose_scoreboard;
    int unsigned col_ptr[MAX_DIM + 1];
    int unsigned loaded_row[MAX_ENTRIES];
    int unsigned loaded_col[MAX_ENTRIES];
    int unsigned sorted_row[MAX_ENTRIES];
    int unsigned sorted_pos[MAX_ENTRIES];
    int unsigned entry_count, drain_ptr, last_row, res_rows, res_entries;
    int unsigned src_rows, src_cols;
    bit draining;
    res_t expected_results[$];
    int failures;
    int results_seen;

    function void reset_state();
      foreach (col_ptr[i]) col_ptr[i] = 0;
      entry_count = 0;
      drain_ptr = 0;
      last_row = 0;
      res_rows = 0;
      res_entries = 0;
      draining = 0;
      src_rows = 1024;
      src_cols = 1024;
    endfunction

    function void write_register(logic idx, int unsigned val);
      if (idx == REG_SOURCE_ROWS) src_rows = val & 'h7ff;
      else src_cols = val & 'h7ff;
    endfunction

    function int unsigned clamp(int unsigned v);
      return v > MAX_DIM ? MAX_DIM : v;
    endfunction

    // Counting sort over the held entries, stable in load order.
    function void start_transpose();
      int unsigned n, m, pos;
      n = clamp(src_cols);
      m = clamp(src_rows);
      foreach (col_ptr[i]) col_ptr[i] = 0;
      for (int unsigned i = 0; i < entry_count; i++)
        if (loaded_col[i] < n && loaded_row[i] < m) col_ptr[loaded_col[i] + 1]++;
      for (int unsigned i = 2; i <= n; i++) col_ptr[i] += col_ptr[i - 1];
      for (int unsigned i = 0; i < entry_count; i++) begin
        if (loaded_col[i] < n && loaded_row[i] < m) begin
          pos = col_ptr[loaded_col[i]];
          if (pos < MAX_ENTRIES) begin
            sorted_row[pos] = loaded_row[i];
            sorted_pos[pos] = i;
          end
          col_ptr[loaded_col[i]] = pos + 1;
        end
      end
      for (int unsigned i = n; i > 0; i--) col_ptr[i] = col_ptr[i - 1];
      col_ptr[0] = 0;
      res_rows = n;
      res_entries = col_ptr[n];
      drain_ptr = 0;
      draining = 1;
    endfunction

    // Notes one accepted request and queues the result it must produce.
    function void note_request(logic is_fetch, logic [9:0] row, logic [9:0] col, logic fin);
      res_t r;
      int unsigned k;
      r = '0;
      r.kind = KIND_NONE;
      r.err = ERR_OK;
      if (!is_fetch) begin
        if (!draining) begin
          if (entry_count >= MAX_ENTRIES) r.err = ERR_OVERFLOW;
          else if (row < last_row || row >= clamp(src_rows)) r.err = ERR_ROW;
          else if (col >= clamp(src_cols)) r.err = ERR_COL;
          else begin
            loaded_row[entry_count] = row;
            loaded_col[entry_count] = col;
            entry_count++;
            last_row = row;
          end
          if (fin) start_transpose();
        end
      end else if (!draining) begin
        r.err = ERR_EARLY;
      end else begin
        if (drain_ptr <= res_rows) begin
          r.kind = KIND_PTR;
          r.value = 13'(col_ptr[drain_ptr]);
        end else begin
          k = drain_ptr - res_rows - 1;
          r.kind = KIND_ENTRY;
          if (k < MAX_ENTRIES) begin
            r.value = 13'(sorted_row[k]);
            r.spos = 12'(sorted_pos[k]);
          end
        end
        if (drain_ptr >= res_rows + res_entries) begin
          r.done = 1'b1;
          draining = 0;
          entry_count = 0;
          last_row = 0;
          drain_ptr = 0;
        end else begin
          drain_ptr++;
        end
      end
      expected_results.push_back(r);
    endfunction

    // Compares one accepted result with the oldest expectation.
    function void check_result(res_t got);
      res_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: kind %0d value %0d", got.kind, got.value);
        failures++;
        return;
      end
      want = expected_results.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        failures++;
      end
      if (got.value !== want.value) begin
        $error("value: expected %0d, got %0d", want.value, got.value);
        failures++;
      end
      if (got.spos !== want.spos) begin
        $error("source_position: expected %0d, got %0d", want.spos, got.spos);
        failures++;
      end
      if (got.done !== want.done) begin
        $error("drain_done: expected %0d, got %0d", want.done, got.done);
        failures++;
      end
      if (got.err !== want.err) begin
        $error("error_code: expected %0d, got %0d", want.err, got.err);
        failures++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        op = 1'b0;
  logic [9:0]  row_index = '0, col_index = '0;
  logic        final_entry = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [12:0] value;
  logic [11:0] source_position;
  logic        drain_done;
  logic [2:0]  error_code;

  transpose_scoreboard sb = new();
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int requests_sent = 0;
  int matrices_done = 0;
  int idle_count = 0;
  int read_failures = 0;

  sparse_block_matrix_transpose i_dut (.*);

  always #2 clk = ~clk;

  // Receiver: random stalls, plus a long hold-off counted here on request.
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    res_t got;
    if (!rst && out_valid && out_ready) begin
      got.kind = kind;
      got.value = value;
      got.spos = source_position;
      got.done = drain_done;
      got.err = error_code;
      sb.check_result(got);
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_count <= 0;
    end else if (idle_count >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // Offers one request and holds it until it is accepted.
  task automatic send_request(logic is_fetch, logic [9:0] row, logic [9:0] col, logic fin);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    op = is_fetch;
    row_index = row;
    col_index = col;
    final_entry = fin;
    do @(posedge clk); while (!in_ready);
    sb.note_request(is_fetch, row, col, fin);
    requests_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Waits until every expected result has arrived and the block has settled.
  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  // APB write followed by a read back of the same register.
  task automatic write_register(logic idx, int unsigned val);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = 3'(idx) << 2;
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (prdata[10:0] !== 11'(val)) begin
      $error("register %0d read back: expected %0d, got %0d", idx, val & 'h7ff, prdata[10:0]);
      read_failures++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    sb.write_register(idx, val);
  endtask

  task automatic set_shape(int unsigned rows, int unsigned cols);
    write_register(REG_SOURCE_ROWS, rows);
    write_register(REG_SOURCE_COLS, cols);
  endtask

  // Fetches until the drain completes, with the odd ignored load mixed in.
  task automatic drain_matrix(int noise_pct);
    while (sb.draining) begin
      if ($urandom_range(99) < noise_pct)
        send_request(1'b0, 10'($urandom), 10'($urandom), 1'($urandom));
      else
        send_request(1'b1, 10'($urandom), 10'($urandom), 1'($urandom));
    end
    matrices_done++;
  endtask

  // One well-formed matrix with random content and some malformed requests.
  task automatic random_matrix(int unsigned entries, int noise_pct);
    int unsigned rows, cols, row;
    rows = sb.clamp(sb.src_rows);
    cols = sb.clamp(sb.src_cols);
    row = 0;
    for (int unsigned i = 0; i < entries; i++) begin
      if ($urandom_range(99) < 50 && row + 1 < rows)
        row = $urandom_range(rows - 1, row);
      if ($urandom_range(99) < noise_pct) begin
        case ($urandom_range(2))
          0: send_request(1'b1, 10'($urandom), 10'($urandom), 1'b0);
          1: send_request(1'b0, 10'($urandom), 10'($urandom), 1'b0);
          default: send_request(1'b0, 10'(row), 10'($urandom_range(1023, cols > 0 ? cols : 0)),
                                1'b0);
        endcase
      end
      send_request(1'b0, 10'(row), 10'(cols > 0 ? $urandom_range(cols - 1) : 0),
                   1'(i + 1 == entries));
    end
    if (!sb.draining) send_request(1'b0, 10'($urandom), 10'($urandom), 1'b1);
    drain_matrix(noise_pct);
  endtask

  initial begin
    int unsigned mode;
    sb.reset_state();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed: early fetch, field extremes, disorder and column range, late config change.
    send_request(1'b1, 10'd0, 10'd0, 1'b0);
    send_request(1'b0, 10'd0, 10'd0, 1'b0);
    send_request(1'b0, 10'd1023, 10'd1023, 1'b0);
    send_request(1'b0, 10'd512, 10'd5, 1'b0);
    wait_drained();
    set_shape(1024, 1024);
    send_request(1'b0, 10'd1023, 10'd0, 1'b0);
    wait_drained();
    set_shape(2047, 6);
    send_request(1'b0, 10'd1023, 10'd0, 1'b1);
    drain_matrix(0);
    wait_drained();
    set_shape(10, 4);
    send_request(1'b0, 10'd2, 10'd3, 1'b0);
    send_request(1'b0, 10'd2, 10'd4, 1'b0);
    send_request(1'b0, 10'd3, 10'd1, 1'b0);
    send_request(1'b0, 10'd8, 10'd0, 1'b0);
    send_request(1'b0, 10'd9, 10'd1, 1'b0);
    send_request(1'b0, 10'd10, 10'd1, 1'b0);
    send_request(1'b0, 10'd7, 10'd2, 1'b0);
    wait_drained();
    // Rows 8 and 9 fall out of range before the sort starts.
    write_register(REG_SOURCE_ROWS, 5);
    send_request(1'b0, 10'd9, 10'd0, 1'b1);
    send_request(1'b0, 10'd1, 10'd1, 1'b0);
    drain_matrix(0);
    wait_drained();
    // Empty shapes: every load is rejected and the drain is one pointer.
    set_shape(0, 0);
    send_request(1'b0, 10'd0, 10'd0, 1'b1);
    drain_matrix(0);
    wait_drained();

    // Random matrices through the idling phases, mostly small shapes.
    while (requests_sent < RANDOM_REQS - 60) begin
      mode = matrices_done % 4;
      sender_idle_pct = (mode == 1 || mode == 3) ? (mode == 1 ? 65 : 28) : 0;
      receiver_stall_pct = (mode == 2 || mode == 3) ? (mode == 2 ? 65 : 28) : 0;
      wait_drained();
      case ($urandom_range(9))
        0: set_shape($urandom_range(1024, 1), $urandom_range(8, 1));
        1: set_shape($urandom_range(2047, 1025), $urandom_range(3, 1));
        default: set_shape($urandom_range(40, 1), $urandom_range(24, 1));
      endcase
      if (matrices_done % 7 == 3) hold_requests++;
      random_matrix($urandom_range(40, 1), 12);
    end

    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Covered %0d requests and %0d matrices, %0d results checked.",
             requests_sent, matrices_done, sb.results_seen);
    $display("Shapes ranged from empty to clamped row counts, with rejected loads mixed in.");
    if (sb.failures == 0 && read_failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/sbmt_pkg.sv
rtl/core/sbmt_front.sv
rtl/core/sbmt_queue.sv
rtl/core/sbmt_back.sv
rtl/core/sparse_block_matrix_transpose.sv
rtl/core/sbmt_checker.sv
verif/sparse_block_matrix_transpose_test.sv
